/* hdl/tkf_pkg.sv */
// Shared types, constants and helpers of the tilt Kalman fusion block.
package tkf_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned DevW    = 13;
  localparam int unsigned AngleW  = 29;
  localparam int unsigned GainW   = 17;
  localparam int unsigned NoiseW  = 16;
  localparam int unsigned PerrW   = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 17;

  localparam int unsigned MulAw   = 48;
  localparam int unsigned MulBw   = 24;
  localparam int unsigned MulPw   = MulAw + MulBw;
  localparam int unsigned SqrtRw  = 50;
  localparam int unsigned SqrtQw  = SqrtRw / 2;
  localparam int unsigned DivW    = 32;

  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic [PerrW-1:0] DevMax = '1;
  localparam logic signed [AngleW-1:0] AngleMax = 29'sh0FFF_FFFF;
  localparam logic signed [AngleW-1:0] AngleMin = 29'sh1000_0000;

  localparam logic [SampleW-1:0] AccelOffsetRst = 12'd1860;
  localparam logic [SampleW-1:0] GyroOffsetRst  = 12'd2048;
  localparam logic [GainW-1:0]   GyroGainRst    = 17'h1D8BB;
  localparam logic [NoiseW-1:0]  ProcNoiseRst   = 16'd128;
  localparam logic [NoiseW-1:0]  MeasNoiseRst   = 16'd5120;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_OFFSET  = 3'd0,
    CFG_GYRO_OFFSET   = 3'd1,
    CFG_GYRO_GAIN     = 3'd2,
    CFG_PROCESS_NOISE = 3'd3,
    CFG_MEASURE_NOISE = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GYRO, ST_QQ, ST_PP, ST_SQ1, ST_PP2, ST_RR, ST_NORM,
    ST_DIV, ST_SQ2, ST_BLEND, ST_OMK, ST_SQ3, ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [MulAw-1:0] a;
    logic [MulBw-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [SqrtRw-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  function automatic logic signed [AngleW-1:0] sat_angle(input logic signed [31:0] x);
    logic signed [AngleW-1:0] r;
    if (x > 32'sh0FFF_FFFF) begin
      r = AngleMax;
    end else if (x < -32'sh1000_0000) begin
      r = AngleMin;
    end else begin
      r = x[AngleW-1:0];
    end
    return r;
  endfunction

  function automatic logic [PerrW-1:0] sat_dev(input logic [SqrtQw-1:0] x);
    return x[PerrW] ? DevMax : x[PerrW-1:0];
  endfunction

endpackage

/* hdl/tkf_if.sv */
// Handshake interfaces for the sample, result and register write channels.
interface tkf_in_if;
  import tkf_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] accel_sample;
  logic [SampleW-1:0] gyro_sample;
  modport source (output valid, accel_sample, gyro_sample, input ready);
  modport sink (input valid, accel_sample, gyro_sample, output ready);
endinterface

interface tkf_out_if;
  import tkf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] angle_estimate;
  logic signed [DevW-1:0]   gyro_deviation;
  logic signed [DevW-1:0]   accel_deviation;
  modport source (output valid, angle_estimate, gyro_deviation, accel_deviation,
                  input ready);
  modport sink (input valid, angle_estimate, gyro_deviation, accel_deviation,
                output ready);
endinterface

interface tkf_cfg_if;
  import tkf_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/tkf_mul.sv */
// Shift-add multiplier that consumes one multiplier bit per cycle.
module tkf_mul import tkf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mul_req_t         req_i,
  output logic             done_o,
  output logic [MulPw-1:0] prod_o
);

  logic [MulPw-1:0] acc_q, acc_d;
  logic [MulAw-1:0] a_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q;
  logic [MulAw:0]   sum;

  always_comb begin
    sum   = {1'b0, acc_q[MulPw-1:MulBw]} + (acc_q[0] ? {1'b0, a_q} : '0);
    acc_d = {sum, acc_q[MulBw-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(MulBw);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= {{MulAw{1'b0}}, req_i.b};
      a_q   <= req_i.a;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* hdl/tkf_sqrt.sv */
// Floor square root, two radicand bits and one root bit per cycle.
module tkf_sqrt import tkf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sqrt_req_t         req_i,
  output logic              done_o,
  output logic [SqrtQw-1:0] root_o
);

  logic [SqrtRw-1:0] rad_q;
  logic [SqrtQw:0]   rem_q, rem_d;
  logic [SqrtQw-1:0] root_q, root_d;
  logic [4:0]        cnt_q;
  logic              busy_q, done_q;
  logic [SqrtQw+2:0] r2, trial;

  always_comb begin
    r2    = {rem_q, rad_q[SqrtRw-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    if (r2 >= trial) begin
      rem_d  = (SqrtQw+1)'(r2 - trial);
      root_d = {root_q[SqrtQw-2:0], 1'b1};
    end else begin
      rem_d  = r2[SqrtQw:0];
      root_d = {root_q[SqrtQw-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(SqrtQw);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SqrtRw-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hdl/tkf_div.sv */
// Restoring divider for num * 2^32 / den with num <= den, one quotient bit per cycle.
module tkf_div import tkf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  div_req_t      req_i,
  output logic          done_o,
  output logic [DivW:0] quot_o
);

  logic [DivW:0]   rem_q, diff;
  logic [DivW-1:0] den_q;
  logic [DivW:0]   quot_q;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q, ge;

  always_comb begin
    ge   = rem_q >= {1'b0, den_q};
    diff = ge ? rem_q - {1'b0, den_q} : rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DivW + 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.num};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= {diff[DivW-1:0], 1'b0};
      quot_q <= {quot_q[DivW-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* hdl/tilt_kalman_fusion_top.sv */
// Top level of the tilt Kalman fusion block: sequencer, state and shared serial units.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   in_i     | sink      | accel_sample, gyro_sample
//   out_o    | source    | angle_estimate, gyro_deviation, accel_deviation
//   cfg_i    | sink      | index, data (register write, always ready)
//
// A result takes seven serial multiplies, three serial roots, a divide and the normalizing
// shifts; when the gain denominator is zero the divide, the shifts and the second root are
// skipped. The shared bit-serial units set the pace; one request is worked on at a time.
// Reset returns the angle and error deviation to zero and the registers to defaults.
// A finished result waits in the output register; the next one waits in ST_FIN until it is out.
module tilt_kalman_fusion_top import tkf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tkf_in_if.sink    in_i,
  tkf_out_if.source out_o,
  tkf_cfg_if.sink   cfg_i
);

  logic [SampleW-1:0] accel_off_q, gyro_off_q;
  logic [GainW-1:0]   gain_q;
  logic [NoiseW-1:0]  qn_q, rn_q;

  state_e state_q, state_d;

  logic signed [AngleW-1:0] angle_q, pred_q, upd_q;
  logic [PerrW-1:0]         perr_q;
  logic signed [DevW-1:0]   adev_q, gdev_q;
  logic                     gsign_q;
  logic [48:0]              acc_q;
  logic [47:0]              num_q, pp2_q;
  logic [16:0]              k_q;

  logic                     out_valid_q;
  logic signed [AngleW-1:0] out_angle_q;
  logic signed [DevW-1:0]   out_gdev_q, out_adev_q;

  mul_req_t  mul_req;
  sqrt_req_t sqrt_req;
  div_req_t  div_req;
  logic             mul_done, sqrt_done, div_done;
  logic [MulPw-1:0]  prod;
  logic [SqrtQw-1:0] root;
  logic [DivW:0]     quot;

  logic                   in_fire;
  logic signed [DevW-1:0] adev_in, gdev_in;
  logic [11:0]            gdev_mag;
  logic [16:0]            gain_mag;
  logic [PerrW-1:0]       qw, rw, root_sat;
  logic [48:0]            pq_sum, den_sum;
  logic signed [29:0]     diff;
  logic [29:0]            diff_mag;
  logic [16:0]            k_root, omk;
  logic signed [30:0]     gstep;
  logic signed [47:0]     bprod, bshift;
  logic signed [31:0]     pred_sum, upd_sum;

  tkf_mul  u_mul  (.clk_i, .rst_ni, .req_i(mul_req),  .done_o(mul_done),  .prod_o(prod));
  tkf_sqrt u_sqrt (.clk_i, .rst_ni, .req_i(sqrt_req), .done_o(sqrt_done), .root_o(root));
  tkf_div  u_div  (.clk_i, .rst_ni, .req_i(div_req),  .done_o(div_done),  .quot_o(quot));

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    adev_in  = $signed({1'b0, in_i.accel_sample}) - $signed({1'b0, accel_off_q});
    gdev_in  = $signed({1'b0, in_i.gyro_sample}) - $signed({1'b0, gyro_off_q});
    gdev_mag = gdev_in[DevW-1] ? 12'(-gdev_in) : gdev_in[11:0];
    gain_mag = gain_q[GainW-1] ? (~gain_q + 17'd1) : gain_q;
    qw       = {qn_q, 8'h00};
    rw       = {rn_q, 8'h00};
    root_sat = sat_dev(root);
    pq_sum   = acc_q + {1'b0, prod[47:0]};
    den_sum  = {1'b0, pp2_q} + {1'b0, prod[47:0]};
    diff     = $signed({adev_q[DevW-1], adev_q, 16'h0000}) - $signed({pred_q[AngleW-1], pred_q});
    diff_mag = diff[29] ? 30'(-diff) : diff[29:0];
    k_root   = (root > SqrtQw'(OneQ16)) ? OneQ16 : root[16:0];
    omk      = OneQ16 - k_q;
    gstep    = gsign_q ? -$signed({2'b00, prod[28:0]}) : $signed({2'b00, prod[28:0]});
    pred_sum = $signed({{3{angle_q[AngleW-1]}}, angle_q}) + 32'(gstep);
    bprod    = diff[29] ? -$signed({1'b0, prod[46:0]}) : $signed({1'b0, prod[46:0]});
    bshift   = bprod >>> 16;
    upd_sum  = $signed({{3{pred_q[AngleW-1]}}, pred_q}) + bshift[31:0];
  end

  // Sequencer: each unit's done pulse launches the next step of the update.
  always_comb begin
    state_d  = state_q;
    mul_req  = '0;
    sqrt_req = '0;
    div_req  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mul_req = '{start: 1'b1, a: MulAw'(gain_mag), b: MulBw'(gdev_mag)};
          state_d = ST_GYRO;
        end
      end
      ST_GYRO: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: MulAw'(qw), b: qw};
          state_d = ST_QQ;
        end
      end
      ST_QQ: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: MulAw'(perr_q), b: perr_q};
          state_d = ST_PP;
        end
      end
      ST_PP: begin
        if (mul_done) begin
          sqrt_req = '{start: 1'b1, rad: SqrtRw'(pq_sum)};
          state_d  = ST_SQ1;
        end
      end
      ST_SQ1: begin
        if (sqrt_done) begin
          mul_req = '{start: 1'b1, a: MulAw'(root_sat), b: root_sat};
          state_d = ST_PP2;
        end
      end
      ST_PP2: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: MulAw'(rw), b: rw};
          state_d = ST_RR;
        end
      end
      ST_RR: begin
        if (mul_done) begin
          if (den_sum == '0) begin
            // Zero denominator: gain is zero and the prediction stands.
            mul_req = '{start: 1'b1, a: MulAw'(diff_mag), b: '0};
            state_d = ST_BLEND;
          end else begin
            state_d = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (acc_q[48:32] == '0) begin
          div_req = '{start: 1'b1, num: num_q[31:0], den: acc_q[31:0]};
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          sqrt_req = '{start: 1'b1, rad: SqrtRw'(quot)};
          state_d  = ST_SQ2;
        end
      end
      ST_SQ2: begin
        if (sqrt_done) begin
          mul_req = '{start: 1'b1, a: MulAw'(diff_mag), b: MulBw'(k_root)};
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (mul_done) begin
          mul_req = '{start: 1'b1, a: pp2_q, b: MulBw'(omk)};
          state_d = ST_OMK;
        end
      end
      ST_OMK: begin
        if (mul_done) begin
          sqrt_req = '{start: 1'b1, rad: SqrtRw'(prod[63:16])};
          state_d  = ST_SQ3;
        end
      end
      ST_SQ3: begin
        if (sqrt_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_off_q <= AccelOffsetRst;
      gyro_off_q  <= GyroOffsetRst;
      gain_q      <= GyroGainRst;
      qn_q        <= ProcNoiseRst;
      rn_q        <= MeasNoiseRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_ACCEL_OFFSET:  accel_off_q <= cfg_i.data[SampleW-1:0];
        CFG_GYRO_OFFSET:   gyro_off_q  <= cfg_i.data[SampleW-1:0];
        CFG_GYRO_GAIN:     gain_q      <= cfg_i.data[GainW-1:0];
        CFG_PROCESS_NOISE: qn_q        <= cfg_i.data[NoiseW-1:0];
        CFG_MEASURE_NOISE: rn_q        <= cfg_i.data[NoiseW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q     <= '0;
      perr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_SQ3 && sqrt_done) begin
        perr_q <= root_sat;
      end
      if (state_q == ST_FIN && state_d == ST_IDLE) begin
        angle_q     <= upd_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      adev_q  <= adev_in;
      gdev_q  <= gdev_in;
      gsign_q <= gdev_in[DevW-1] ^ gain_q[GainW-1];
    end
    if (state_q == ST_GYRO && mul_done) begin
      pred_q <= sat_angle(pred_sum);
    end
    if (state_q == ST_QQ && mul_done) begin
      acc_q <= {1'b0, prod[47:0]};
    end
    if (state_q == ST_PP2 && mul_done) begin
      pp2_q <= prod[47:0];
    end
    if (state_q == ST_RR && mul_done) begin
      acc_q <= den_sum;
      num_q <= pp2_q;
      k_q   <= '0;
    end
    if (state_q == ST_NORM && acc_q[48:32] != '0) begin
      acc_q <= {1'b0, acc_q[48:1]};
      num_q <= {1'b0, num_q[47:1]};
    end
    if (state_q == ST_SQ2 && sqrt_done) begin
      k_q <= k_root;
    end
    if (state_q == ST_BLEND && mul_done) begin
      upd_q <= sat_angle(upd_sum);
    end
    if (state_q == ST_FIN && state_d == ST_IDLE) begin
      out_angle_q <= upd_q;
      out_gdev_q  <= gdev_q;
      out_adev_q  <= adev_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.angle_estimate  = out_angle_q;
  assign out_o.gyro_deviation  = out_gdev_q;
  assign out_o.accel_deviation = out_adev_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_GYRO)
    else $error("accepted request did not start the gyro multiply");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OMK |-> k_q <= OneQ16)
    else $error("Kalman gain above one");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_o.ready) |=> state_q == ST_FIN)
    else $error("pending result overwritten");

  a_norm_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> acc_q[48:32] == '0)
    else $error("divisor not normalized below 2^32");
`endif

endmodule
